/* hdl/assert_macros.svh */
// Shared assertion macros for the sentence checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsc assertion failed");

`endif

/* hdl/nsc_pkg.sv */
package nsc_pkg;

  typedef enum logic [1:0] {
    PhIdle,
    PhBody,
    PhHex1,
    PhHex2
  } phase_t;

  localparam logic [2:0] HdrLen    = 3'd5;
  localparam logic [2:0] TalkerLen = 3'd2;

  localparam logic [7:0] CharStart = "$";
  localparam logic [7:0] CharStar  = "*";
  localparam logic [7:0] CharZero  = "0";
  localparam logic [7:0] CharNine  = "9";
  localparam logic [7:0] CharUpA   = "A";
  localparam logic [7:0] CharUpF   = "F";
  localparam logic [7:0] CharLoA   = "a";
  localparam logic [7:0] CharLoF   = "f";
  localparam logic [7:0] HexTen    = 8'd10;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StCsumErr = 2'd1;
  localparam logic [1:0] StTalker  = 2'd2;
  localparam logic [1:0] StKind    = 2'd3;

  localparam logic [2:0] TalkUnknown = 3'd0;
  localparam logic [2:0] TalkGps     = 3'd1;
  localparam logic [2:0] TalkGlonass = 3'd2;
  localparam logic [2:0] TalkBeidou  = 3'd3;
  localparam logic [2:0] TalkGnss    = 3'd4;

  localparam logic [1:0] KindUnknown = 2'd0;
  localparam logic [1:0] KindGga     = 2'd1;
  localparam logic [1:0] KindGsv     = 2'd2;
  localparam logic [1:0] KindRmc     = 2'd3;

  localparam logic [15:0] CodeGp  = "GP";
  localparam logic [15:0] CodeGl  = "GL";
  localparam logic [15:0] CodeBd  = "BD";
  localparam logic [15:0] CodeGn  = "GN";
  localparam logic [23:0] CodeGga = "GGA";
  localparam logic [23:0] CodeGsv = "GSV";
  localparam logic [23:0] CodeRmc = "RMC";

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] talker_system;
    logic [1:0] sentence_kind;
    logic [7:0] received_checksum;
    logic [7:0] computed_checksum;
  } result_t;

  // Bit 4 flags a valid hex digit, bits 3..0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= CharUpA && c <= CharUpF) begin
        v = c - CharUpA + HexTen;
        hex_digit = {1'b1, v[3:0]};
      end else if (c >= CharLoA && c <= CharLoF) begin
        v = c - CharLoA + HexTen;
        hex_digit = {1'b1, v[3:0]};
      end else if (c >= CharZero && c <= CharNine) begin
        v = c - CharZero;
        hex_digit = {1'b1, v[3:0]};
      end else begin
        hex_digit = 5'd0;
      end
    end
  endfunction

  function automatic logic [2:0] decode_talker(input logic [2:0] pos, input logic [15:0] chars);
    begin
      if (pos < TalkerLen) begin
        decode_talker = TalkUnknown;
      end else begin
        case (chars)
          CodeGp:  decode_talker = TalkGps;
          CodeGl:  decode_talker = TalkGlonass;
          CodeBd:  decode_talker = TalkBeidou;
          CodeGn:  decode_talker = TalkGnss;
          default: decode_talker = TalkUnknown;
        endcase
      end
    end
  endfunction

  function automatic logic [1:0] decode_kind(input logic [2:0] pos, input logic [23:0] chars);
    begin
      if (pos < HdrLen) begin
        decode_kind = KindUnknown;
      end else begin
        case (chars)
          CodeGga: decode_kind = KindGga;
          CodeGsv: decode_kind = KindGsv;
          CodeRmc: decode_kind = KindRmc;
          default: decode_kind = KindUnknown;
        endcase
      end
    end
  endfunction

endpackage

/* hdl/nsc_parser.sv */
`include "assert_macros.svh"

module nsc_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_text_byte,
  input  logic             slot_free,
  output logic             res_load,
  output nsc_pkg::result_t res
);

  logic                in_vld_r, in_vld_nxt;
  logic [7:0]          byte_r, byte_nxt;
  nsc_pkg::phase_t     phase_r, phase_nxt;
  logic [2:0]          hdr_pos_r, hdr_pos_nxt;
  logic [7:0]          acc_r, acc_nxt;
  logic [15:0]         talker_r, talker_nxt;
  logic [23:0]         type_r, type_nxt;
  logic [4:0]          hi_nib_r, hi_nib_nxt;

  logic                fire;
  logic                accept;
  logic                is_start;
  logic                res_vld;
  logic [4:0]          lo_nib;
  logic                digits_ok;
  logic [7:0]          rx_sum;
  logic [2:0]          talker_code;
  logic [1:0]          kind_code;
  logic                sentence_clear;
  logic                parse_done;

  assign fire     = in_vld_r && (slot_free || !res_vld);
  assign in_stall = in_vld_r && res_vld && !slot_free;
  assign accept   = in_valid && !in_stall;
  assign is_start = (byte_r == nsc_pkg::CharStart);

  assign sentence_clear = (phase_r == nsc_pkg::PhBody) && (acc_r == 8'd0) &&
                          (hdr_pos_r == 3'd0);
  assign parse_done     = (phase_r == nsc_pkg::PhIdle) && (hi_nib_r == 5'd0);

  always_comb begin
    in_vld_nxt = in_vld_r;
    byte_nxt   = byte_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
      byte_nxt   = in_text_byte;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  // Next-state logic of the sentence parser.
  always_comb begin
    phase_nxt   = phase_r;
    hdr_pos_nxt = hdr_pos_r;
    acc_nxt     = acc_r;
    talker_nxt  = talker_r;
    type_nxt    = type_r;
    hi_nib_nxt  = hi_nib_r;
    if (fire) begin
      if (is_start) begin
        phase_nxt   = nsc_pkg::PhBody;
        hdr_pos_nxt = 3'd0;
        acc_nxt     = 8'd0;
        talker_nxt  = 16'd0;
        type_nxt    = 24'd0;
        hi_nib_nxt  = 5'd0;
      end else begin
        case (phase_r)
          nsc_pkg::PhBody: begin
            if (byte_r == nsc_pkg::CharStar) begin
              phase_nxt = nsc_pkg::PhHex1;
            end else begin
              acc_nxt = acc_r ^ byte_r;
              if (hdr_pos_r < nsc_pkg::TalkerLen) begin
                talker_nxt  = {talker_r[7:0], byte_r};
                hdr_pos_nxt = hdr_pos_r + 3'd1;
              end else if (hdr_pos_r < nsc_pkg::HdrLen) begin
                type_nxt    = {type_r[15:0], byte_r};
                hdr_pos_nxt = hdr_pos_r + 3'd1;
              end
            end
          end
          nsc_pkg::PhHex1: begin
            hi_nib_nxt = nsc_pkg::hex_digit(byte_r);
            phase_nxt  = nsc_pkg::PhHex2;
          end
          nsc_pkg::PhHex2: begin
            hi_nib_nxt = 5'd0;
            phase_nxt  = nsc_pkg::PhIdle;
          end
          default: begin
            phase_nxt = nsc_pkg::PhIdle;
          end
        endcase
      end
    end
  end

  // Result of the second checksum digit.
  always_comb begin
    lo_nib      = nsc_pkg::hex_digit(byte_r);
    digits_ok   = hi_nib_r[4] && lo_nib[4];
    rx_sum      = digits_ok ? {hi_nib_r[3:0], lo_nib[3:0]} : 8'd0;
    talker_code = nsc_pkg::decode_talker(hdr_pos_r, talker_r);
    kind_code   = nsc_pkg::decode_kind(hdr_pos_r, type_r);
    res_vld     = (phase_r == nsc_pkg::PhHex2) && !is_start;
    res_load    = fire && res_vld;

    res.talker_system     = talker_code;
    res.sentence_kind     = kind_code;
    res.received_checksum = rx_sum;
    res.computed_checksum = acc_r;
    if (!digits_ok || rx_sum == 8'd0 || acc_r == 8'd0 || rx_sum != acc_r) begin
      res.status = nsc_pkg::StCsumErr;
    end else if (talker_code == nsc_pkg::TalkUnknown) begin
      res.status = nsc_pkg::StTalker;
    end else if (kind_code == nsc_pkg::KindUnknown) begin
      res.status = nsc_pkg::StKind;
    end else begin
      res.status = nsc_pkg::StOk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      phase_r   <= nsc_pkg::PhIdle;
      hdr_pos_r <= 3'd0;
      acc_r     <= 8'd0;
      talker_r  <= 16'd0;
      type_r    <= 24'd0;
      hi_nib_r  <= 5'd0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      phase_r   <= phase_nxt;
      hdr_pos_r <= hdr_pos_nxt;
      acc_r     <= acc_nxt;
      talker_r  <= talker_nxt;
      type_r    <= type_nxt;
      hi_nib_r  <= hi_nib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  `NSC_ASSERT_NXT(a_start_clears, clk, rst_n, fire && is_start, sentence_clear)
  `NSC_ASSERT_NXT(a_result_ends, clk, rst_n, res_load, parse_done)
  `NSC_ASSERT_IMP(a_hdr_bound, clk, rst_n, 1'b1, hdr_pos_r <= nsc_pkg::HdrLen)

endmodule

/* hdl/nsc_out_buf.sv */
module nsc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_load,
  input  nsc_pkg::result_t res,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_stall,
  output nsc_pkg::result_t out_res
);

  logic             out_vld_r, out_vld_nxt;
  nsc_pkg::result_t res_r, res_nxt;

  assign slot_free = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign out_res   = res_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    res_nxt     = res_r;
    if (res_load) begin
      out_vld_nxt = 1'b1;
      res_nxt     = res;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

/* hdl/nmea_sentence_checker_unit.sv */
// A status reaches the out_ port after the second checksum digit passes the input register, then the result register.
// Throughput: one text byte per cycle while in_stall is low; the input register and the result register set it.
// A request waiting at the output does not stop input bytes until a second result needs the slot.
// Reset (rst_n low, synchronous) returns the parser to idle, waiting for a start character,
// and empties both the input register and the result register.
module nmea_sentence_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [2:0] out_talker_system,
  output logic [1:0] out_sentence_kind,
  output logic [7:0] out_received_checksum,
  output logic [7:0] out_computed_checksum
);

  logic             slot_free;
  logic             res_load;
  nsc_pkg::result_t res;
  nsc_pkg::result_t out_res;

  nsc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .slot_free    (slot_free),
    .res_load     (res_load),
    .res          (res)
  );

  nsc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status            = out_res.status;
  assign out_talker_system     = out_res.talker_system;
  assign out_sentence_kind     = out_res.sentence_kind;
  assign out_received_checksum = out_res.received_checksum;
  assign out_computed_checksum = out_res.computed_checksum;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import nsc_pkg::*;

  class sentence_status_board;
    phase_t      phase;
    logic [2:0]  hdr_pos;
    logic [7:0]  xor_acc;
    logic [15:0] talker_chars;
    logic [23:0] kind_chars;
    logic [4:0]  first_digit;
    result_t     expected_q[$];
    int unsigned mismatch_count;

    function new();
      phase          = PhIdle;
      hdr_pos        = 3'd0;
      xor_acc        = 8'd0;
      talker_chars   = 16'd0;
      kind_chars     = 24'd0;
      first_digit    = 5'd0;
      mismatch_count = 0;
    endfunction

    task report(string what);
      if (mismatch_count < 60) begin
        $display("%0t mismatch: %s", $time, what);
      end
      mismatch_count++;
    endtask

    function logic [4:0] nibble_of(logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CharZero && c <= CharNine) begin
        v = c - CharZero;
        return {1'b1, v[3:0]};
      end else if (c >= CharUpA && c <= CharUpF) begin
        v = c - CharUpA + 8'd10;
        return {1'b1, v[3:0]};
      end else if (c >= CharLoA && c <= CharLoF) begin
        v = c - CharLoA + 8'd10;
        return {1'b1, v[3:0]};
      end
      return 5'd0;
    endfunction

    function void take_byte(logic [7:0] b);
      logic [4:0] second;
      logic       digits_ok;
      result_t    r;
      if (b == CharStart) begin
        phase        = PhBody;
        hdr_pos      = 3'd0;
        xor_acc      = 8'd0;
        talker_chars = 16'd0;
        kind_chars   = 24'd0;
        first_digit  = 5'd0;
      end else begin
        case (phase)
          PhBody: begin
            if (b == CharStar) begin
              phase = PhHex1;
            end else begin
              xor_acc = xor_acc ^ b;
              if (hdr_pos < TalkerLen) begin
                talker_chars = {talker_chars[7:0], b};
                hdr_pos = hdr_pos + 3'd1;
              end else if (hdr_pos < HdrLen) begin
                kind_chars = {kind_chars[15:0], b};
                hdr_pos = hdr_pos + 3'd1;
              end
            end
          end
          PhHex1: begin
            first_digit = nibble_of(b);
            phase = PhHex2;
          end
          PhHex2: begin
            second = nibble_of(b);
            digits_ok = first_digit[4] && second[4];
            r.received_checksum = digits_ok ? {first_digit[3:0], second[3:0]} : 8'd0;
            r.computed_checksum = xor_acc;
            r.talker_system = TalkUnknown;
            if (hdr_pos >= TalkerLen) begin
              case (talker_chars)
                CodeGp:  r.talker_system = TalkGps;
                CodeGl:  r.talker_system = TalkGlonass;
                CodeBd:  r.talker_system = TalkBeidou;
                CodeGn:  r.talker_system = TalkGnss;
                default: r.talker_system = TalkUnknown;
              endcase
            end
            r.sentence_kind = KindUnknown;
            if (hdr_pos >= HdrLen) begin
              case (kind_chars)
                CodeGga: r.sentence_kind = KindGga;
                CodeGsv: r.sentence_kind = KindGsv;
                CodeRmc: r.sentence_kind = KindRmc;
                default: r.sentence_kind = KindUnknown;
              endcase
            end
            if (!digits_ok || r.received_checksum == 8'd0 || xor_acc == 8'd0
                || r.received_checksum != xor_acc) begin
              r.status = StCsumErr;
            end else if (r.talker_system == TalkUnknown) begin
              r.status = StTalker;
            end else if (r.sentence_kind == KindUnknown) begin
              r.status = StKind;
            end else begin
              r.status = StOk;
            end
            expected_q.push_back(r);
            phase = PhIdle;
            first_digit = 5'd0;
          end
          default: phase = PhIdle;
        endcase
      end
    endfunction

    task check_status(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("status %0d with no sentence pending", got.status));
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.talker_system != want.talker_system)
          report($sformatf("talker %0d, want %0d", got.talker_system, want.talker_system));
        if (got.sentence_kind != want.sentence_kind)
          report($sformatf("kind %0d, want %0d", got.sentence_kind, want.sentence_kind));
        if (got.received_checksum != want.received_checksum)
          report($sformatf("received sum %h, want %h", got.received_checksum,
                           want.received_checksum));
        if (got.computed_checksum != want.computed_checksum)
          report($sformatf("computed sum %h, want %h", got.computed_checksum,
                           want.computed_checksum));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_status;
  logic [2:0] out_talker_system;
  logic [1:0] out_sentence_kind;
  logic [7:0] out_received_checksum;
  logic [7:0] out_computed_checksum;

  sentence_status_board sb = new();
  logic [7:0] text_q[$];

  nmea_sentence_checker_unit u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_text_byte          (in_text_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_talker_system     (out_talker_system),
    .out_sentence_kind     (out_sentence_kind),
    .out_received_checksum (out_received_checksum),
    .out_computed_checksum (out_computed_checksum)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.take_byte(in_text_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_status(result_t'({out_status, out_talker_system, out_sentence_kind,
                                 out_received_checksum, out_computed_checksum}));
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CharStart || b == CharStar);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return CharZero + 8'(n);
    return (lower ? CharLoA : CharUpA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] xor_of(string s);
    logic [7:0] x;
    x = 8'd0;
    for (int i = 0; i < s.len(); i++) x = x ^ s[i];
    return x;
  endfunction

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic push_sum(logic [7:0] v);
    text_q.push_back(hex_char(v[7:4], 1'($urandom_range(1))));
    text_q.push_back(hex_char(v[3:0], 1'($urandom_range(1))));
  endtask

  task automatic gen_sentence();
    logic [7:0] hdr[5];
    logic [7:0] sum;
    logic [7:0] b;
    int unsigned hlen;
    int unsigned mode;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(plain_byte());
    end
    case ($urandom_range(4))
      0: {hdr[0], hdr[1]} = CodeGp;
      1: {hdr[0], hdr[1]} = CodeGl;
      2: {hdr[0], hdr[1]} = CodeBd;
      3: {hdr[0], hdr[1]} = CodeGn;
      default: begin
        hdr[0] = plain_byte();
        hdr[1] = plain_byte();
      end
    endcase
    case ($urandom_range(3))
      0: {hdr[2], hdr[3], hdr[4]} = CodeGga;
      1: {hdr[2], hdr[3], hdr[4]} = CodeGsv;
      2: {hdr[2], hdr[3], hdr[4]} = CodeRmc;
      default: begin
        hdr[2] = plain_byte();
        hdr[3] = plain_byte();
        hdr[4] = plain_byte();
      end
    endcase
    hlen = ($urandom_range(99) < 15) ? $urandom_range(0, 4) : 5;
    text_q.push_back(CharStart);
    sum = 8'd0;
    for (int i = 0; i < hlen; i++) begin
      text_q.push_back(hdr[i]);
      sum = sum ^ hdr[i];
    end
    if (hlen == 5) begin
      repeat ($urandom_range(0, 6)) begin
        b = ($urandom_range(3) == 0) ? 8'h2c : plain_byte();
        text_q.push_back(b);
        sum = sum ^ b;
      end
    end
    if ($urandom_range(99) < 8) return;
    text_q.push_back(CharStar);
    mode = $urandom_range(99);
    if (mode < 70) begin
      push_sum(sum);
    end else if (mode < 80) begin
      push_sum(sum ^ 8'($urandom_range(1, 255)));
    end else if (mode < 90) begin
      case ($urandom_range(5))
        0: b = 8'h2f;
        1: b = 8'h3a;
        2: b = 8'h40;
        3: b = 8'h47;
        4: b = 8'h60;
        default: b = 8'h67;
      endcase
      if ($urandom_range(1)) begin
        text_q.push_back(b);
        text_q.push_back(hex_char(sum[3:0], 1'($urandom_range(1))));
      end else begin
        text_q.push_back(hex_char(sum[7:4], 1'($urandom_range(1))));
        text_q.push_back(b);
      end
    end else if (mode < 95) begin
      if ($urandom_range(1)) text_q.push_back(hex_char(sum[7:4], 1'b0));
    end else begin
      text_q.push_back(plain_byte());
      text_q.push_back(plain_byte());
    end
  endtask

  initial begin
    int unsigned cyc;
    out_stall <= 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 330 && cyc < 450) begin
        out_stall <= 1'b1;
      end else if (cyc >= 700 && cyc < 950) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 30);
      end
    end
  end

  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned idx;
    bit quiet;
    logic [7:0] gn_sum;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_text_byte <= 8'd0;

    text_q.push_back(8'hff);
    text_q.push_back(8'h00);
    push_str("$GP");
    push_str("$GNRMC*");
    gn_sum = xor_of("GNRMC");
    text_q.push_back(hex_char(gn_sum[7:4], 1'b1));
    text_q.push_back(hex_char(gn_sum[3:0], 1'b1));
    push_str("$B*z0");
    push_str("$*00");
    while (text_q.size() < 650) gen_sentence();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    while (idx < text_q.size()) begin
      @(posedge clk);
      if (in_valid && !in_stall) idx++;
      if (!(in_valid && in_stall)) begin
        quiet = (idx >= 250 && idx < 420) ? 1'b0 : ($urandom_range(99) < 30);
        if (idx < text_q.size() && !quiet) begin
          in_valid     <= 1'b1;
          in_text_byte <= text_q[idx];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end

    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.report($sformatf("%0d statuses never arrived", sb.expected_q.size()));
    end
    if (sb.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
